// ===== rtl/vrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared types, widths and register indexes for the vertex rotate/project unit.
// ----------------------------------------------------------------------------
package vrp_pkg;

    localparam int COORD_W  = 16;               // vertex and screen coordinates
    localparam int TRIG_W   = 16;               // Q15 sine and cosine
    localparam int QSHIFT   = 15;               // Q15 product scaling
    localparam int ZOOM_W   = 14;
    localparam int CENTER_W = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int QP1_W    = 17;               // floor(16b * 16b / 2^15)
    localparam int QP2_W    = 19;               // floor(18b * 16b / 2^15)
    localparam int ROT_W    = 18;               // rotated coordinates
    localparam int DEN_FULL_W = 20;             // signed denominator before clamp
    localparam int DEN_W    = 18;               // clamped, positive divisor
    localparam int NUM_FULL_W = ROT_W + ZOOM_W + 1;
    localparam int NUM_W    = 32;               // numerator magnitude
    localparam int DIV_STAGES = NUM_W;          // one quotient bit per stage

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIN_YAW     = 3'd0,
        REG_COS_YAW     = 3'd1,
        REG_SIN_PITCH   = 3'd2,
        REG_COS_PITCH   = 3'd3,
        REG_TRANSLATION = 3'd4,
        REG_ZOOM        = 3'd5,
        REG_CENTER_X    = 3'd6,
        REG_CENTER_Y    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] vert_x;
        logic signed [COORD_W-1:0] vert_y;
        logic signed [COORD_W-1:0] vert_z;
    } vrp_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] screen_x;
        logic signed [COORD_W-1:0] screen_y;
        logic signed [COORD_W-1:0] depth;
    } vrp_out_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0]  sin_yaw;
        logic signed [TRIG_W-1:0]  cos_yaw;
        logic signed [TRIG_W-1:0]  sin_pitch;
        logic signed [TRIG_W-1:0]  cos_pitch;
        logic signed [COORD_W-1:0] translation;
        logic [ZOOM_W-1:0]         zoom;
        logic [CENTER_W-1:0]       center_x;
        logic [CENTER_W-1:0]       center_y;
    } vrp_cfg_t;

    // rotated vertex handed from the rotation stages to the projection stages
    typedef struct packed {
        logic                    valid;
        logic signed [ROT_W-1:0] x1;
        logic signed [ROT_W-1:0] y2;
        logic signed [ROT_W-1:0] z2;
    } vrp_rot_t;

endpackage

// ===== rtl/vrp_rotate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_rotate
// Four stage rotation: yaw products, yaw sums, pitch products, pitch sums.
// ----------------------------------------------------------------------------
module vrp_rotate
    import vrp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  logic     in_valid,
    input  vrp_in_t  in_data,
    input  vrp_cfg_t cfg,
    output vrp_rot_t rot
);

    logic signed [2*COORD_W-1:0]      p_xc, p_zs, p_xs, p_zc;
    logic signed [2*COORD_W-1:0]      p_yc, p_ys;
    logic signed [ROT_W+TRIG_W-1:0]   p_z1s, p_z1c;

    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [QP1_W-1:0]  m_xc_reg, m_zs_reg, m_xs_reg, m_zc_reg;
    logic signed [COORD_W-1:0] y0_s1_reg, y0_s2_reg;
    logic signed [ROT_W-1:0]  x1_s2_reg, z1_s2_reg, x1_s3_reg, x1_s4_reg;
    logic signed [QP1_W-1:0]  m_yc_reg, m_ys_reg;
    logic signed [QP2_W-1:0]  m_z1s_reg, m_z1c_reg;
    logic signed [ROT_W-1:0]  y2_reg, z2_reg;
    logic signed [ROT_W-1:0]  x1_next, z1_next;
    logic signed [QP2_W+1-1:0] y2_full, z2_full;

    // rotate about y
    assign p_xc = in_data.vert_x * cfg.cos_yaw;
    assign p_zs = in_data.vert_z * cfg.sin_yaw;
    assign p_xs = in_data.vert_x * cfg.sin_yaw;
    assign p_zc = in_data.vert_z * cfg.cos_yaw;

    assign x1_next = {m_xc_reg[QP1_W-1], m_xc_reg} - {m_zs_reg[QP1_W-1], m_zs_reg};
    assign z1_next = {m_xs_reg[QP1_W-1], m_xs_reg} + {m_zc_reg[QP1_W-1], m_zc_reg};

    // rotate about x
    assign p_yc  = y0_s2_reg * cfg.cos_pitch;
    assign p_ys  = y0_s2_reg * cfg.sin_pitch;
    assign p_z1s = z1_s2_reg * cfg.sin_pitch;
    assign p_z1c = z1_s2_reg * cfg.cos_pitch;

    assign y2_full = {{(QP2_W+1-QP1_W){m_yc_reg[QP1_W-1]}}, m_yc_reg}
                   - {m_z1s_reg[QP2_W-1], m_z1s_reg};
    assign z2_full = {{(QP2_W+1-QP1_W){m_ys_reg[QP1_W-1]}}, m_ys_reg}
                   + {m_z1c_reg[QP2_W-1], m_z1c_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // arithmetic shift of the product is the floor of the q15 scaling
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_xc_reg  <= p_xc[2*COORD_W-1:QSHIFT];
            m_zs_reg  <= p_zs[2*COORD_W-1:QSHIFT];
            m_xs_reg  <= p_xs[2*COORD_W-1:QSHIFT];
            m_zc_reg  <= p_zc[2*COORD_W-1:QSHIFT];
            y0_s1_reg <= in_data.vert_y;

            x1_s2_reg <= x1_next;
            z1_s2_reg <= z1_next;
            y0_s2_reg <= y0_s1_reg;

            m_yc_reg  <= p_yc[2*COORD_W-1:QSHIFT];
            m_ys_reg  <= p_ys[2*COORD_W-1:QSHIFT];
            m_z1s_reg <= p_z1s[ROT_W+TRIG_W-1:QSHIFT];
            m_z1c_reg <= p_z1c[ROT_W+TRIG_W-1:QSHIFT];
            x1_s3_reg <= x1_s2_reg;

            y2_reg    <= y2_full[ROT_W-1:0];
            z2_reg    <= z2_full[ROT_W-1:0];
            x1_s4_reg <= x1_s3_reg;
        end
    end

    assign rot.valid = v4_reg;
    assign rot.x1    = x1_s4_reg;
    assign rot.y2    = y2_reg;
    assign rot.z2    = z2_reg;

endmodule

// ===== rtl/vrp_project.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_project
// Perspective projection: zoom products, denominator clamp, two restoring
// dividers with one quotient bit per stage, centre offset and output register.
// ----------------------------------------------------------------------------
module vrp_project
    import vrp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  vrp_rot_t rot,
    input  vrp_cfg_t cfg,
    output logic     out_valid,
    output vrp_out_t out_data
);

    logic signed [NUM_FULL_W-1:0] p_x, p_y, neg_px, neg_py;
    logic signed [ZOOM_W:0]       zoom_s;
    logic signed [DEN_FULL_W-1:0] den_next;

    logic                          v5_reg;
    logic signed [NUM_FULL_W-1:0]  px_reg, py_reg;
    logic signed [DEN_FULL_W-1:0]  den_reg;
    logic [COORD_W-1:0]            dz5_reg;

    // divider stage registers, index 0 is the operand stage
    logic                 dv_reg  [0:DIV_STAGES];
    logic [NUM_W-1:0]     nqx_reg [0:DIV_STAGES];
    logic [NUM_W-1:0]     nqy_reg [0:DIV_STAGES];
    logic [DEN_W-1:0]     rx_reg  [0:DIV_STAGES];
    logic [DEN_W-1:0]     ry_reg  [0:DIV_STAGES];
    logic [DEN_W-1:0]     d_reg   [0:DIV_STAGES];
    logic                 sgx_reg [0:DIV_STAGES];
    logic                 sgy_reg [0:DIV_STAGES];
    logic [COORD_W-1:0]   dz_reg  [0:DIV_STAGES];

    logic                 ov_reg;
    vrp_out_t             od_reg;
    logic [COORD_W-1:0]   qx16, qy16;

    assign zoom_s   = {1'b0, cfg.zoom};
    assign p_x      = rot.x1 * zoom_s;
    assign p_y      = rot.y2 * zoom_s;
    assign den_next = {{(DEN_FULL_W-ZOOM_W){1'b0}}, cfg.zoom}
                    + {{(DEN_FULL_W-ROT_W){rot.z2[ROT_W-1]}}, rot.z2}
                    + {{(DEN_FULL_W-COORD_W){cfg.translation[COORD_W-1]}}, cfg.translation};
    assign neg_px   = -px_reg;
    assign neg_py   = -py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            dv_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v5_reg <= rot.valid;
            dv_reg[0] <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg  <= p_x;
            py_reg  <= p_y;
            den_reg <= den_next;
            dz5_reg <= rot.z2[COORD_W-1:0] + cfg.translation;

            // magnitudes and clamped divisor
            sgx_reg[0] <= px_reg[NUM_FULL_W-1];
            sgy_reg[0] <= py_reg[NUM_FULL_W-1];
            nqx_reg[0] <= px_reg[NUM_FULL_W-1] ? neg_px[NUM_W-1:0] : px_reg[NUM_W-1:0];
            nqy_reg[0] <= py_reg[NUM_FULL_W-1] ? neg_py[NUM_W-1:0] : py_reg[NUM_W-1:0];
            rx_reg[0]  <= '0;
            ry_reg[0]  <= '0;
            // non-positive denominator divides by one
            d_reg[0]   <= (!den_reg[DEN_FULL_W-1] && (den_reg != '0))
                          ? den_reg[DEN_W-1:0] : DEN_W'(1);
            dz_reg[0]  <= dz5_reg;
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        logic [DEN_W:0] shx, shy;
        logic [DEN_W:0] dx_diff, dy_diff;
        logic           qbx, qby;

        assign shx     = {rx_reg[k], nqx_reg[k][NUM_W-1]};
        assign shy     = {ry_reg[k], nqy_reg[k][NUM_W-1]};
        assign dx_diff = shx - {1'b0, d_reg[k]};
        assign dy_diff = shy - {1'b0, d_reg[k]};
        assign qbx     = (shx >= {1'b0, d_reg[k]});
        assign qby     = (shy >= {1'b0, d_reg[k]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rx_reg[k+1]  <= qbx ? dx_diff[DEN_W-1:0] : shx[DEN_W-1:0];
                ry_reg[k+1]  <= qby ? dy_diff[DEN_W-1:0] : shy[DEN_W-1:0];
                nqx_reg[k+1] <= {nqx_reg[k][NUM_W-2:0], qbx};
                nqy_reg[k+1] <= {nqy_reg[k][NUM_W-2:0], qby};
                d_reg[k+1]   <= d_reg[k];
                sgx_reg[k+1] <= sgx_reg[k];
                sgy_reg[k+1] <= sgy_reg[k];
                dz_reg[k+1]  <= dz_reg[k];
            end
        end
    end

    // quotient truncates toward zero, so the sign goes back on the magnitude
    assign qx16 = sgx_reg[DIV_STAGES] ? (COORD_W'(0) - nqx_reg[DIV_STAGES][COORD_W-1:0])
                                      : nqx_reg[DIV_STAGES][COORD_W-1:0];
    assign qy16 = sgy_reg[DIV_STAGES] ? (COORD_W'(0) - nqy_reg[DIV_STAGES][COORD_W-1:0])
                                      : nqy_reg[DIV_STAGES][COORD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            ov_reg <= dv_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            od_reg.screen_x <= qx16 + {{(COORD_W-CENTER_W){1'b0}}, cfg.center_x};
            od_reg.screen_y <= qy16 + {{(COORD_W-CENTER_W){1'b0}}, cfg.center_y};
            od_reg.depth    <= dz_reg[DIV_STAGES];
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule

// ===== rtl/vertex_rotate_project_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_rotate_project_unit
// Rotates a vertex about y then x and projects it onto the screen.
// ----------------------------------------------------------------------------
// Usage:
//   input channel in_valid/in_stall/in_data carries one vertex per
//   transaction; output channel out_valid/out_stall/out_data carries the
//   screen x, screen y and depth of that vertex, in the same order.
//   The pipeline takes one vertex every cycle unless it is stalled. From
//   input transaction to out_valid a vertex passes four rotation stages,
//   two projection stages, 32 divider stages (one quotient bit each) and
//   the output register; the divider depth dominates the latency.
//   When the receiver stalls a valid result the whole pipeline holds and
//   in_stall is raised in the same cycle; nothing is dropped or repeated.
//   Configuration is written through cfg_wr_en/cfg_index/cfg_wdata and
//   should only change while no transaction is in flight.
//   Reset clears every pipeline valid bit and loads the default angles
//   (cosine 32255, sine 0), translation 3000, zoom 1000, centre 0,0.
// ----------------------------------------------------------------------------
module vertex_rotate_project_unit
    import vrp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  vrp_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output vrp_out_t              out_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    vrp_cfg_t cfg_reg;
    vrp_rot_t rot;
    logic     adv;

    // the pipeline moves unless a finished result is held at the output
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sin_yaw     <= 16'sd0;
            cfg_reg.cos_yaw     <= 16'sd32255;
            cfg_reg.sin_pitch   <= 16'sd0;
            cfg_reg.cos_pitch   <= 16'sd32255;
            cfg_reg.translation <= 16'sd3000;
            cfg_reg.zoom        <= 14'd1000;
            cfg_reg.center_x    <= '0;
            cfg_reg.center_y    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_SIN_YAW:     cfg_reg.sin_yaw     <= cfg_wdata;
                REG_COS_YAW:     cfg_reg.cos_yaw     <= cfg_wdata;
                REG_SIN_PITCH:   cfg_reg.sin_pitch   <= cfg_wdata;
                REG_COS_PITCH:   cfg_reg.cos_pitch   <= cfg_wdata;
                REG_TRANSLATION: cfg_reg.translation <= cfg_wdata;
                REG_ZOOM:        cfg_reg.zoom        <= cfg_wdata[ZOOM_W-1:0];
                REG_CENTER_X:    cfg_reg.center_x    <= cfg_wdata[CENTER_W-1:0];
                REG_CENTER_Y:    cfg_reg.center_y    <= cfg_wdata[CENTER_W-1:0];
                default:         ;
            endcase
        end
    end

    vrp_rotate u_rotate (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .rot      (rot)
    );

    vrp_project u_project (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .rot       (rot),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/vrp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_checker
// Port level checks for the vertex rotate/project unit.
// ----------------------------------------------------------------------------
module vrp_checker
    import vrp_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input vrp_out_t out_data
);

    // input is only held back by a stalled result
    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed or dropped");

    // no result is valid right after reset is released
    a_no_early_out: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

    a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output is free");

endmodule

bind vertex_rotate_project_unit vrp_checker u_vrp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
